>>> sv/tfn_pkg.sv
// ----------------------------------------------------------------------------
// tfn_pkg - shared widths and types for the triangle face normal pipeline
// Widths of the edge, product, cross, scaling, root and quotient datapaths,
// and the sideband structs that travel with an item through the stages.
// ----------------------------------------------------------------------------
`default_nettype none

package tfn_pkg;

  localparam int unsigned CoordW  = 32;  // Q16.16 vertex coordinate
  localparam int unsigned EdgeW   = 33;  // exact coordinate difference
  localparam int unsigned ProdW   = 64;  // product of an e1 and an e0 magnitude
  localparam int unsigned CrossW  = 65;  // cross component magnitude
  localparam int unsigned IndexW  = 24;  // vertex index
  localparam int unsigned ScaleW  = 31;  // normalized magnitude
  localparam int unsigned SumW    = 64;  // sum of squared magnitudes
  localparam int unsigned RootW   = 32;  // integer square root
  localparam int unsigned QuotW   = 15;  // Q1.14 magnitude quotient
  localparam int unsigned NormW   = 16;  // signed Q1.14 output

  typedef struct packed {
    logic [IndexW-1:0] idx_a;
    logic [IndexW-1:0] idx_b;
    logic [IndexW-1:0] idx_c;
  } tfn_idx_t;

  // Everything the back end needs besides the length: indices, signs,
  // the degenerate mark and the scaled magnitudes.
  typedef struct packed {
    tfn_idx_t                idx;
    logic [2:0]              neg;
    logic                    degen;
    logic [2:0][ScaleW-1:0]  mag;
  } tfn_carry_t;

endpackage

`default_nettype wire

>>> sv/tfn_cross.sv
// ----------------------------------------------------------------------------
// tfn_cross - edge vectors and exact cross product
// Three stages: edge differences, edge magnitude products, signed combine
// into sign and 65-bit magnitude per component.
// ----------------------------------------------------------------------------
`default_nettype none

module tfn_cross (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     en,
  input  logic                                     in_valid,
  input  logic [2:0][tfn_pkg::CoordW-1:0]          va,
  input  logic [2:0][tfn_pkg::CoordW-1:0]          vb,
  input  logic [2:0][tfn_pkg::CoordW-1:0]          vc,
  input  tfn_pkg::tfn_idx_t                        idx,
  output logic                                     out_valid,
  output tfn_pkg::tfn_idx_t                        out_idx,
  output logic [2:0]                               out_neg,
  output logic [2:0][tfn_pkg::CrossW-1:0]          out_mag
);

  localparam int unsigned CoordW = tfn_pkg::CoordW;
  localparam int unsigned EdgeW  = tfn_pkg::EdgeW;
  localparam int unsigned ProdW  = tfn_pkg::ProdW;
  localparam int unsigned CrossW = tfn_pkg::CrossW;

  function automatic logic [CoordW-1:0] edge_mag(input logic [EdgeW-1:0] e);
    logic [EdgeW-1:0] n;
    n = -e;
    return e[EdgeW-1] ? n[CoordW-1:0] : e[CoordW-1:0];
  endfunction

  logic                          v1_r, v2_r, v3_r;
  tfn_pkg::tfn_idx_t             idx1_r, idx2_r, idx3_r;
  logic [2:0][EdgeW-1:0]         e1_r, e0_r, e1_nxt, e0_nxt;
  logic [2:0][ProdW-1:0]         p1_r, p2_r, p1_nxt, p2_nxt;
  logic [2:0]                    s1_r, s2_r, s1_nxt, s2_nxt;
  logic [2:0][CrossW-1:0]        mag_r, mag_nxt;
  logic [2:0]                    neg_r, neg_nxt;

  // Stage 1: e1 = c - a, e0 = c - b
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      e1_nxt[k] = {vc[k][CoordW-1], vc[k]} - {va[k][CoordW-1], va[k]};
      e0_nxt[k] = {vc[k][CoordW-1], vc[k]} - {vb[k][CoordW-1], vb[k]};
    end
  end

  // Stage 2: component k is e1[k+1]*e0[k+2] - e1[k+2]*e0[k+1]
  for (genvar k = 0; k < 3; k++) begin : g_prod
    localparam int unsigned KA = (k + 1) % 3;
    localparam int unsigned KB = (k + 2) % 3;
    assign p1_nxt[k] = ProdW'(edge_mag(e1_r[KA])) * ProdW'(edge_mag(e0_r[KB]));
    assign p2_nxt[k] = ProdW'(edge_mag(e1_r[KB])) * ProdW'(edge_mag(e0_r[KA]));
    assign s1_nxt[k] = e1_r[KA][EdgeW-1] ^ e0_r[KB][EdgeW-1];
    assign s2_nxt[k] = ~(e1_r[KB][EdgeW-1] ^ e0_r[KA][EdgeW-1]);
  end

  // Stage 3: signed add of the two terms in sign-magnitude form
  always_comb begin
    logic [CrossW-1:0] sum;
    logic [CrossW-1:0] d12;
    logic [ProdW-1:0]  d21;
    for (int k = 0; k < 3; k++) begin
      sum = {1'b0, p1_r[k]} + {1'b0, p2_r[k]};
      d12 = {1'b0, p1_r[k]} - {1'b0, p2_r[k]};
      d21 = p2_r[k] - p1_r[k];
      if (s1_r[k] == s2_r[k]) begin
        mag_nxt[k] = sum;
        neg_nxt[k] = s1_r[k];
      end else if (!d12[CrossW-1]) begin
        mag_nxt[k] = {1'b0, d12[ProdW-1:0]};
        neg_nxt[k] = s1_r[k];
      end else begin
        mag_nxt[k] = {1'b0, d21};
        neg_nxt[k] = s2_r[k];
      end
      if (mag_nxt[k] == '0) begin
        neg_nxt[k] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e1_r   <= e1_nxt;
      e0_r   <= e0_nxt;
      idx1_r <= idx;
      p1_r   <= p1_nxt;
      p2_r   <= p2_nxt;
      s1_r   <= s1_nxt;
      s2_r   <= s2_nxt;
      idx2_r <= idx1_r;
      mag_r  <= mag_nxt;
      neg_r  <= neg_nxt;
      idx3_r <= idx2_r;
    end
  end

  assign out_valid = v3_r;
  assign out_idx   = idx3_r;
  assign out_neg   = neg_r;
  assign out_mag   = mag_r;

endmodule

`default_nettype wire

>>> sv/tfn_scale.sv
// ----------------------------------------------------------------------------
// tfn_scale - common scaling and sum of squares
// Four stages: bit length of the largest component, shift of all three
// magnitudes to 31 bits, squares, three-way sum.
// ----------------------------------------------------------------------------
`default_nettype none

module tfn_scale (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 en,
  input  logic                                 in_valid,
  input  tfn_pkg::tfn_idx_t                    idx,
  input  logic [2:0]                           neg,
  input  logic [2:0][tfn_pkg::CrossW-1:0]      cmag,
  output logic                                 out_valid,
  output tfn_pkg::tfn_carry_t                  out_carry,
  output logic [tfn_pkg::SumW-1:0]             out_sum
);

  localparam int unsigned CrossW = tfn_pkg::CrossW;
  localparam int unsigned ScaleW = tfn_pkg::ScaleW;
  localparam int unsigned SumW   = tfn_pkg::SumW;
  localparam int unsigned SqW    = 2 * ScaleW;
  localparam int unsigned LenW   = $clog2(CrossW + 1);
  localparam int unsigned WideW  = CrossW + ScaleW;

  logic                        v1_r, v2_r, v3_r, v4_r;
  logic [LenW-1:0]             len_r, len_nxt;
  logic [CrossW-1:0]           any_bits;
  logic [2:0][CrossW-1:0]      cmag1_r;
  tfn_pkg::tfn_idx_t           idx1_r;
  logic [2:0]                  neg1_r;
  tfn_pkg::tfn_carry_t         car2_r, car2_nxt, car3_r, car4_r;
  logic [2:0][SqW-1:0]         sq_r, sq_nxt;
  logic [SumW-1:0]             sum_r, sum_nxt;

  // Stage 1: bit length of the largest magnitude equals that of the OR
  assign any_bits = cmag[0] | cmag[1] | cmag[2];

  always_comb begin
    len_nxt = '0;
    for (int i = 0; i < CrossW; i++) begin
      if (any_bits[i]) begin
        len_nxt = LenW'(i + 1);
      end
    end
  end

  // Stage 2: {mag, 31 zeros} >> len lands the top bit at position 30
  always_comb begin
    logic [WideW-1:0] wide;
    car2_nxt.idx   = idx1_r;
    car2_nxt.neg   = neg1_r;
    car2_nxt.degen = (len_r == '0);
    for (int k = 0; k < 3; k++) begin
      wide = {cmag1_r[k], {ScaleW{1'b0}}} >> len_r;
      car2_nxt.mag[k] = wide[ScaleW-1:0];
    end
  end

  // Stage 3 and 4: squares, then their sum
  for (genvar k = 0; k < 3; k++) begin : g_sq
    assign sq_nxt[k] = SqW'(car2_r.mag[k]) * SqW'(car2_r.mag[k]);
  end

  assign sum_nxt = SumW'(sq_r[0]) + SumW'(sq_r[1]) + SumW'(sq_r[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      len_r   <= len_nxt;
      cmag1_r <= cmag;
      idx1_r  <= idx;
      neg1_r  <= neg;
      car2_r  <= car2_nxt;
      sq_r    <= sq_nxt;
      car3_r  <= car2_r;
      sum_r   <= sum_nxt;
      car4_r  <= car3_r;
    end
  end

  assign out_valid = v4_r;
  assign out_carry = car4_r;
  assign out_sum   = sum_r;

endmodule

`default_nettype wire

>>> sv/tfn_isqrt.sv
// ----------------------------------------------------------------------------
// tfn_isqrt - pipelined integer square root
// Digit-by-digit restoring root of a 64-bit radicand, two root bits per
// stage over sixteen stages.
// ----------------------------------------------------------------------------
`default_nettype none

module tfn_isqrt (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [tfn_pkg::SumW-1:0]      in_sum,
  input  tfn_pkg::tfn_carry_t           in_carry,
  output logic                          out_valid,
  output logic [tfn_pkg::RootW-1:0]     out_root,
  output tfn_pkg::tfn_carry_t           out_carry
);

  localparam int unsigned SumW   = tfn_pkg::SumW;
  localparam int unsigned RootW  = tfn_pkg::RootW;
  localparam int unsigned RemW   = RootW + 3;
  localparam int unsigned Stages = SumW / 4;

  typedef struct packed {
    logic [RemW-1:0]  rem;
    logic [RootW-1:0] root;
  } sqrt_st_t;

  function automatic sqrt_st_t sqrt_step(input sqrt_st_t cur, input logic [1:0] pair);
    sqrt_st_t        res;
    logic [RemW-1:0] acc;
    logic [RemW-1:0] trial;
    acc   = {cur.rem[RemW-3:0], pair};
    trial = RemW'({cur.root, 2'b01});
    if (acc >= trial) begin
      res.rem  = acc - trial;
      res.root = {cur.root[RootW-2:0], 1'b1};
    end else begin
      res.rem  = acc;
      res.root = {cur.root[RootW-2:0], 1'b0};
    end
    return res;
  endfunction

  logic [Stages-1:0]    v_r;
  sqrt_st_t             st_r [Stages];
  logic [SumW-1:0]      s_r  [Stages];
  tfn_pkg::tfn_carry_t  c_r  [Stages];

  for (genvar g = 0; g < Stages; g++) begin : g_stage
    sqrt_st_t            prev;
    sqrt_st_t            mid;
    sqrt_st_t            st_nxt;
    logic [SumW-1:0]     s_prev;
    logic                v_prev;
    tfn_pkg::tfn_carry_t c_prev;

    if (g == 0) begin : g_head
      assign prev   = '0;
      assign s_prev = in_sum;
      assign v_prev = in_valid;
      assign c_prev = in_carry;
    end else begin : g_body
      assign prev   = st_r[g-1];
      assign s_prev = s_r[g-1];
      assign v_prev = v_r[g-1];
      assign c_prev = c_r[g-1];
    end

    // two radicand bit pairs, most significant first
    assign mid    = sqrt_step(prev, s_prev[SumW-1-4*g -: 2]);
    assign st_nxt = sqrt_step(mid, s_prev[SumW-3-4*g -: 2]);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[g] <= 1'b0;
      end else if (en) begin
        v_r[g] <= v_prev;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st_r[g] <= st_nxt;
        s_r[g]  <= s_prev;
        c_r[g]  <= c_prev;
      end
    end
  end

  assign out_valid = v_r[Stages-1];
  assign out_root  = st_r[Stages-1].root;
  assign out_carry = c_r[Stages-1];

endmodule

`default_nettype wire

>>> sv/tfn_div.sv
// ----------------------------------------------------------------------------
// tfn_div - pipelined rounded quotient for three components
// One setup stage forms m*2^15 + r and 2r, then one restoring quotient bit
// per stage for fifteen stages, three lanes side by side.
// ----------------------------------------------------------------------------
`default_nettype none

module tfn_div (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  en,
  input  logic                                  in_valid,
  input  logic [tfn_pkg::RootW-1:0]             in_root,
  input  tfn_pkg::tfn_carry_t                   in_carry,
  output logic                                  out_valid,
  output logic [2:0][tfn_pkg::QuotW-1:0]        out_quot,
  output tfn_pkg::tfn_carry_t                   out_carry
);

  localparam int unsigned ScaleW = tfn_pkg::ScaleW;
  localparam int unsigned RootW  = tfn_pkg::RootW;
  localparam int unsigned QuotW  = tfn_pkg::QuotW;
  localparam int unsigned NumW   = ScaleW + QuotW + 1;
  localparam int unsigned DivW   = RootW + 1;
  localparam int unsigned ShW    = NumW + 1;

  logic                         v0_r;
  logic [2:0][NumW-1:0]         num0_r, num0_nxt;
  logic [DivW-1:0]              d0_r;
  tfn_pkg::tfn_carry_t          c0_r;

  logic [QuotW-1:0]             v_r;
  logic [2:0][NumW-1:0]         rem_r [QuotW];
  logic [2:0][QuotW-1:0]        q_r   [QuotW];
  logic [DivW-1:0]              d_r   [QuotW];
  tfn_pkg::tfn_carry_t          c_r   [QuotW];

  // Setup: numerator m*2^15 + r, divisor 2r gives round half away from zero
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      num0_nxt[k] = {1'b0, in_carry.mag[k], {QuotW{1'b0}}} + NumW'(in_root);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num0_r <= num0_nxt;
      d0_r   <= {in_root, 1'b0};
      c0_r   <= in_carry;
    end
  end

  for (genvar g = 0; g < QuotW; g++) begin : g_step
    localparam int unsigned Bit = QuotW - 1 - g;

    logic [2:0][NumW-1:0]   rem_prev, rem_nxt;
    logic [2:0][QuotW-1:0]  q_prev, q_nxt;
    logic [DivW-1:0]        d_prev;
    logic                   v_prev;
    tfn_pkg::tfn_carry_t    c_prev;
    logic [ShW-1:0]         shifted;

    if (g == 0) begin : g_head
      assign rem_prev = num0_r;
      assign q_prev   = '0;
      assign d_prev   = d0_r;
      assign v_prev   = v0_r;
      assign c_prev   = c0_r;
    end else begin : g_body
      assign rem_prev = rem_r[g-1];
      assign q_prev   = q_r[g-1];
      assign d_prev   = d_r[g-1];
      assign v_prev   = v_r[g-1];
      assign c_prev   = c_r[g-1];
    end

    assign shifted = ShW'(d_prev) << Bit;

    always_comb begin
      for (int k = 0; k < 3; k++) begin
        if ({1'b0, rem_prev[k]} >= shifted) begin
          rem_nxt[k] = rem_prev[k] - shifted[NumW-1:0];
          q_nxt[k]   = {q_prev[k][QuotW-2:0], 1'b1};
        end else begin
          rem_nxt[k] = rem_prev[k];
          q_nxt[k]   = {q_prev[k][QuotW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[g] <= 1'b0;
      end else if (en) begin
        v_r[g] <= v_prev;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[g] <= rem_nxt;
        q_r[g]   <= q_nxt;
        d_r[g]   <= d_prev;
        c_r[g]   <= c_prev;
      end
    end
  end

  assign out_valid = v_r[QuotW-1];
  assign out_quot  = q_r[QuotW-1];
  assign out_carry = c_r[QuotW-1];

endmodule

`default_nettype wire

>>> sv/triangle_face_normal.sv
// ----------------------------------------------------------------------------
// triangle_face_normal - unit face normal of a triangle in Q1.14
// Pipeline: each result passes the cross, scale, square root and divide stages
// and then the output register before it shows on out_valid.
// Throughput: one triangle per cycle while in_stall is low; the square root
// and divide stages are fully pipelined, so no unit is shared between items.
// Reset: synchronous, active low; clears every stage valid bit, the output
// register and the skid entry. Payload registers are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module triangle_face_normal (
  input  logic                                 clk,
  input  logic                                 rst_n,

  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [tfn_pkg::CoordW-1:0]    in_vertex_a_x,
  input  logic signed [tfn_pkg::CoordW-1:0]    in_vertex_a_y,
  input  logic signed [tfn_pkg::CoordW-1:0]    in_vertex_a_z,
  input  logic signed [tfn_pkg::CoordW-1:0]    in_vertex_b_x,
  input  logic signed [tfn_pkg::CoordW-1:0]    in_vertex_b_y,
  input  logic signed [tfn_pkg::CoordW-1:0]    in_vertex_b_z,
  input  logic signed [tfn_pkg::CoordW-1:0]    in_vertex_c_x,
  input  logic signed [tfn_pkg::CoordW-1:0]    in_vertex_c_y,
  input  logic signed [tfn_pkg::CoordW-1:0]    in_vertex_c_z,
  input  logic [tfn_pkg::IndexW-1:0]           in_vertex_a_index,
  input  logic [tfn_pkg::IndexW-1:0]           in_vertex_b_index,
  input  logic [tfn_pkg::IndexW-1:0]           in_vertex_c_index,

  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [tfn_pkg::NormW-1:0]     out_normal_x,
  output logic signed [tfn_pkg::NormW-1:0]     out_normal_y,
  output logic signed [tfn_pkg::NormW-1:0]     out_normal_z,
  output logic                                 out_degenerate,
  output logic [tfn_pkg::IndexW-1:0]           out_index_a,
  output logic [tfn_pkg::IndexW-1:0]           out_index_b,
  output logic [tfn_pkg::IndexW-1:0]           out_index_c
);

  localparam int unsigned NormW = tfn_pkg::NormW;

  typedef struct packed {
    logic [2:0][NormW-1:0]  normal;
    logic                   degen;
    tfn_pkg::tfn_idx_t      idx;
  } tfn_res_t;

  // --------------------------------------------------------------------------
  // Pipeline enable. The whole datapath advances together; it only holds
  // when the skid entry is occupied, which happens when another result
  // arrives while the output register holds a stalled result.
  // --------------------------------------------------------------------------
  logic                                   skid_v_r;
  logic                                   out_valid_r;
  logic                                   adv;

  assign adv      = !skid_v_r;
  assign in_stall = skid_v_r;

  // Front end: pack the vertex ports into per-vertex coordinate vectors.
  logic [2:0][tfn_pkg::CoordW-1:0]        va, vb, vc;
  tfn_pkg::tfn_idx_t                      in_idx;

  assign va = {in_vertex_a_z, in_vertex_a_y, in_vertex_a_x};
  assign vb = {in_vertex_b_z, in_vertex_b_y, in_vertex_b_x};
  assign vc = {in_vertex_c_z, in_vertex_c_y, in_vertex_c_x};

  assign in_idx.idx_a = in_vertex_a_index;
  assign in_idx.idx_b = in_vertex_b_index;
  assign in_idx.idx_c = in_vertex_c_index;

  // Cross product: edges, products, signed combine (3 stages).
  logic                                   x_valid;
  tfn_pkg::tfn_idx_t                      x_idx;
  logic [2:0]                             x_neg;
  logic [2:0][tfn_pkg::CrossW-1:0]        x_mag;

  tfn_cross u_cross (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (in_valid),
    .va        (va),
    .vb        (vb),
    .vc        (vc),
    .idx       (in_idx),
    .out_valid (x_valid),
    .out_idx   (x_idx),
    .out_neg   (x_neg),
    .out_mag   (x_mag)
  );

  // Scaling to 31 bits and sum of squares (4 stages).
  logic                                   s_valid;
  tfn_pkg::tfn_carry_t                    s_carry;
  logic [tfn_pkg::SumW-1:0]               s_sum;

  tfn_scale u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (x_valid),
    .idx       (x_idx),
    .neg       (x_neg),
    .cmag      (x_mag),
    .out_valid (s_valid),
    .out_carry (s_carry),
    .out_sum   (s_sum)
  );

  // Vector length as an integer square root (16 stages).
  logic                                   r_valid;
  logic [tfn_pkg::RootW-1:0]              r_root;
  tfn_pkg::tfn_carry_t                    r_carry;

  tfn_isqrt u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (s_valid),
    .in_sum    (s_sum),
    .in_carry  (s_carry),
    .out_valid (r_valid),
    .out_root  (r_root),
    .out_carry (r_carry)
  );

  // Rounded quotient m / r in Q1.14 for each component (16 stages).
  logic                                   d_valid;
  logic [2:0][tfn_pkg::QuotW-1:0]         d_quot;
  tfn_pkg::tfn_carry_t                    d_carry;

  tfn_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (r_valid),
    .in_root   (r_root),
    .in_carry  (r_carry),
    .out_valid (d_valid),
    .out_quot  (d_quot),
    .out_carry (d_carry)
  );

  // --------------------------------------------------------------------------
  // Result formatting: apply the component sign, zero the normal for a
  // degenerate triangle (the divider ran on a zero root and holds junk).
  // --------------------------------------------------------------------------
  tfn_res_t                               res_nxt;

  always_comb begin
    logic [NormW-1:0] mag16;
    res_nxt.degen = d_carry.degen;
    res_nxt.idx   = d_carry.idx;
    for (int k = 0; k < 3; k++) begin
      mag16 = {1'b0, d_quot[k]};
      if (d_carry.degen) begin
        res_nxt.normal[k] = '0;
      end else if (d_carry.neg[k]) begin
        res_nxt.normal[k] = -mag16;
      end else begin
        res_nxt.normal[k] = mag16;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output register plus one skid entry. The last pipeline stage is always
  // drained when the pipe advances: into the output register when it is
  // free or transferring, otherwise into the skid entry. The skid entry
  // refills the output register first once it frees up.
  // --------------------------------------------------------------------------
  tfn_res_t                               out_r, skid_r;
  logic                                   out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_v_r    <= 1'b0;
    end else begin
      if (out_free) begin
        if (skid_v_r) begin
          out_valid_r <= 1'b1;
          skid_v_r    <= 1'b0;
        end else begin
          out_valid_r <= d_valid;
        end
      end else if (adv && d_valid) begin
        skid_v_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_r <= skid_v_r ? skid_r : res_nxt;
    end else if (adv) begin
      skid_r <= res_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_normal_x   = out_r.normal[0];
  assign out_normal_y   = out_r.normal[1];
  assign out_normal_z   = out_r.normal[2];
  assign out_degenerate = out_r.degen;
  assign out_index_a    = out_r.idx.idx_a;
  assign out_index_b    = out_r.idx.idx_b;
  assign out_index_c    = out_r.idx.idx_c;

  // --------------------------------------------------------------------------
  // Checks
  // --------------------------------------------------------------------------
  a_skid_behind_out : assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_valid_r)
    else $error("skid entry occupied while output register is empty");

  a_skid_drains : assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r && !out_stall |=> !skid_v_r)
    else $error("skid entry not drained after output transfer");

  a_degen_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_degenerate |->
      out_normal_x == '0 && out_normal_y == '0 && out_normal_z == '0)
    else $error("degenerate result carries a nonzero normal");

  a_norm_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |->
      out_normal_x >= -16'sd16384 && out_normal_x <= 16'sd16384 &&
      out_normal_y >= -16'sd16384 && out_normal_y <= 16'sd16384 &&
      out_normal_z >= -16'sd16384 && out_normal_z <= 16'sd16384)
    else $error("normal component outside Q1.14 unit range");

endmodule

`default_nettype wire
